// File: hw/rtl/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg: triangle unit normal shared definitions
// Widths, stage payload types and per-stage step functions for the
// root and divide sections of the pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

	localparam int CW       = 24;          // coordinate width
	localparam int EW       = CW + 1;      // edge width
	localparam int PW       = 2 * EW;      // product width
	localparam int XW       = PW + 1;      // cross component width
	localparam int BW       = $clog2(XW + 1);
	localparam int NT       = 24;          // normalized magnitude width
	localparam int SQW      = 2 * NT;      // square width
	localparam int SW       = SQW + 2;     // sum of squares width
	localparam int RSH      = 14;          // radicand pre-shift
	localparam int RADW     = SW + RSH;    // radicand width
	localparam int RW       = RADW / 2;    // root width
	localparam int REMW     = RW + 2;
	localparam int OW       = 18;          // output field width
	localparam int QW       = OW;          // quotient width
	localparam int QSH      = NT - 1;      // numerator shift
	localparam int NW       = NT + QSH + 1;
	localparam int DREM     = RW + 1;
	localparam int ROOT_PER = 4;
	localparam int ROOT_ST  = RW / ROOT_PER;
	localparam int DIV_PER  = 3;
	localparam int DIV_ST   = QW / DIV_PER;
	localparam int IN_BYTES = (9 * CW + 7) / 8;
	localparam int OUT_BYTES = (3 * OW + 7) / 8;
	localparam logic [QW-1:0] UNIT = QW'(1 << 16);

	typedef struct packed {
		logic [REMW-1:0]        rem;
		logic [RW-1:0]          root;
		logic [RADW-1:0]        rad;
		logic [2:0][NT-1:0]     m;
		logic [2:0]             neg;
		logic                   last;
		logic                   deg;
	} sq_t;

	typedef struct packed {
		logic [2:0][DREM-1:0]   rem;
		logic [2:0][QW-1:0]     q;
		logic [2:0][QW-1:0]     n;
		logic [RW-1:0]          len;
		logic [2:0]             neg;
		logic                   last;
		logic                   deg;
	} dv_t;

	function automatic sq_t sqrt_step(sq_t x);
		sq_t y;
		logic [REMW-1:0] r;
		logic [REMW-1:0] t;
		y = x;
		for (int j = 0; j < ROOT_PER; j++) begin
			r = {y.rem[REMW-3:0], y.rad[RADW-1:RADW-2]};
			y.rad = {y.rad[RADW-3:0], 2'b00};
			t = {y.root, 2'b01};
			if (r >= t) begin
				y.rem = r - t;
				y.root = {y.root[RW-2:0], 1'b1};
			end else begin
				y.rem = r;
				y.root = {y.root[RW-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	function automatic dv_t div_step(dv_t x);
		dv_t y;
		logic [DREM-1:0] r;
		y = x;
		for (int j = 0; j < DIV_PER; j++) begin
			for (int i = 0; i < 3; i++) begin
				r = {y.rem[i][DREM-2:0], y.n[i][QW-1]};
				y.n[i] = {y.n[i][QW-2:0], 1'b0};
				if (r >= {1'b0, y.len}) begin
					y.rem[i] = r - {1'b0, y.len};
					y.q[i] = {y.q[i][QW-2:0], 1'b1};
				end else begin
					y.rem[i] = r;
					y.q[i] = {y.q[i][QW-2:0], 1'b0};
				end
			end
		end
		return y;
	endfunction

endpackage

// File: hw/rtl/triangle_unit_normal_top.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_top: unit face normal of a triangle
// Edge vectors, exact cross product, normalization and reciprocal length
// scaling in one stall-able pipeline.
// ----------------------------------------------------------------------------
// Takes one triangle per cycle unless stalled and gives its unit normal in
// Q1.16 through 7 front stages (edges, products, cross, bit length, shift,
// squares, sum), 8 square root stages of 4 root bits each, 6 divide stages of
// 3 quotient bits each and one output register. A stall on the output holds
// every stage. A zero cross product gives a zero normal with degenerate set.
module triangle_unit_normal_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
	input  logic [tun_pkg::IN_BYTES*8-1:0]    s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// normal_x, normal_y, normal_z, zero fill
	output logic [tun_pkg::OUT_BYTES*8-1:0]   m_tdata,
	// degenerate
	output logic                              m_tuser,
	output logic                              m_tlast
);

	localparam int CW = tun_pkg::CW;
	localparam int EW = tun_pkg::EW;
	localparam int PW = tun_pkg::PW;
	localparam int XW = tun_pkg::XW;
	localparam int BW = tun_pkg::BW;
	localparam int NT = tun_pkg::NT;
	localparam int OW = tun_pkg::OW;
	localparam int QW = tun_pkg::QW;
	localparam int RW = tun_pkg::RW;
	localparam int NW = tun_pkg::NW;
	localparam int RS = tun_pkg::ROOT_ST;
	localparam int DS = tun_pkg::DIV_ST;

	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	logic                    v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [EW-1:0]    e_s1 [3];
	logic signed [EW-1:0]    f_s1 [3];
	logic                    last_s1, last_s2, last_s3, last_s4, last_s5, last_s6, last_s7;
	logic signed [PW-1:0]    p_s2 [6];
	logic [XW-1:0]           mag_s3 [3];
	logic [2:0]              neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [XW-1:0]           mag_s4 [3];
	logic [BW-1:0]           bl_s4;
	logic [NT-1:0]           m_s5 [3];
	logic [NT-1:0]           m_s6 [3];
	logic [NT-1:0]           m_s7 [3];
	logic                    deg_s5, deg_s6, deg_s7;
	logic [tun_pkg::SQW-1:0] sq_s6 [3];
	logic [tun_pkg::SW-1:0]  sum_s7;

	logic signed [CW-1:0] crd [9];
	always_comb begin
		for (int i = 0; i < 9; i++) crd[i] = $signed(s_tdata[i*CW +: CW]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	logic signed [XW-1:0] cr [3];
	logic [XW-1:0]        orv;
	logic [BW-1:0]        blen;
	logic [XW-1:0]        sh [3];
	always_comb begin
		cr[0] = XW'(p_s2[0]) - XW'(p_s2[1]);
		cr[1] = XW'(p_s2[2]) - XW'(p_s2[3]);
		cr[2] = XW'(p_s2[4]) - XW'(p_s2[5]);
		orv = mag_s3[0] | mag_s3[1] | mag_s3[2];
		blen = '0;
		for (int i = 0; i < XW; i++) if (orv[i]) blen = BW'(i + 1);
		for (int i = 0; i < 3; i++) begin
			if (bl_s4 >= BW'(NT)) sh[i] = mag_s4[i] >> (bl_s4 - BW'(NT));
			else sh[i] = mag_s4[i] << (BW'(NT) - bl_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e_s1[i] <= EW'(crd[3+i]) - EW'(crd[i]);
				f_s1[i] <= EW'(crd[6+i]) - EW'(crd[i]);
			end
			last_s1 <= s_tlast;
			p_s2[0] <= e_s1[1] * f_s1[2];
			p_s2[1] <= e_s1[2] * f_s1[1];
			p_s2[2] <= e_s1[2] * f_s1[0];
			p_s2[3] <= e_s1[0] * f_s1[2];
			p_s2[4] <= e_s1[0] * f_s1[1];
			p_s2[5] <= e_s1[1] * f_s1[0];
			last_s2 <= last_s1;
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= cr[i][XW-1];
				mag_s3[i] <= cr[i][XW-1] ? $unsigned(-cr[i]) : $unsigned(cr[i]);
			end
			last_s3 <= last_s2;
			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			bl_s4 <= blen;
			last_s4 <= last_s3;
			for (int i = 0; i < 3; i++) m_s5[i] <= sh[i][NT-1:0];
			deg_s5 <= (bl_s4 == '0);
			neg_s5 <= neg_s4;
			last_s5 <= last_s4;
			for (int i = 0; i < 3; i++) sq_s6[i] <= m_s5[i] * m_s5[i];
			m_s6 <= m_s5;
			deg_s6 <= deg_s5;
			neg_s6 <= neg_s5;
			last_s6 <= last_s5;
			sum_s7 <= tun_pkg::SW'(sq_s6[0]) + tun_pkg::SW'(sq_s6[1])
				+ tun_pkg::SW'(sq_s6[2]);
			m_s7 <= m_s6;
			deg_s7 <= deg_s6;
			neg_s7 <= neg_s6;
			last_s7 <= last_s6;
		end
	end

	tun_pkg::sq_t sq_in;
	always_comb begin
		sq_in.rem = '0;
		sq_in.root = '0;
		sq_in.rad = {sum_s7, {tun_pkg::RSH{1'b0}}};
		for (int i = 0; i < 3; i++) sq_in.m[i] = m_s7[i];
		sq_in.neg = neg_s7;
		sq_in.last = last_s7;
		sq_in.deg = deg_s7;
	end

	tun_pkg::sq_t sq_s [RS];
	logic [RS-1:0] sqv_s;
	tun_pkg::dv_t dv_s [DS];
	logic [DS-1:0] dvv_s;

	for (genvar k = 0; k < RS; k++) begin : g_root
		tun_pkg::sq_t src;
		logic         src_v;
		if (k == 0) begin : g_first
			assign src = sq_in;
			assign src_v = v_s7;
		end else begin : g_next
			assign src = sq_s[k-1];
			assign src_v = sqv_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sqv_s[k] <= 1'b0;
			else if (en) sqv_s[k] <= src_v;
		end
		always_ff @(posedge clk) begin
			if (en) sq_s[k] <= tun_pkg::sqrt_step(src);
		end
	end

	tun_pkg::dv_t dv_in;
	logic [NW-1:0] num [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = NW'({sq_s[RS-1].m[i], {tun_pkg::QSH{1'b0}}})
				+ NW'(sq_s[RS-1].root[RW-1:1]);
			dv_in.rem[i] = tun_pkg::DREM'(num[i][NW-1:QW]);
			dv_in.n[i] = num[i][QW-1:0];
			dv_in.q[i] = '0;
		end
		dv_in.len = sq_s[RS-1].root;
		dv_in.neg = sq_s[RS-1].neg;
		dv_in.last = sq_s[RS-1].last;
		dv_in.deg = sq_s[RS-1].deg;
	end

	for (genvar k = 0; k < DS; k++) begin : g_div
		tun_pkg::dv_t src;
		logic         src_v;
		if (k == 0) begin : g_first
			assign src = dv_in;
			assign src_v = sqv_s[RS-1];
		end else begin : g_next
			assign src = dv_s[k-1];
			assign src_v = dvv_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dvv_s[k] <= 1'b0;
			else if (en) dvv_s[k] <= src_v;
		end
		always_ff @(posedge clk) begin
			if (en) dv_s[k] <= tun_pkg::div_step(src);
		end
	end

	logic              vld_q;
	logic [OW-1:0]     nrm_q [3];
	logic              deg_q;
	logic              last_q;
	logic [QW-1:0]     qc [3];
	logic [OW-1:0]     nv [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc[i] = (dv_s[DS-1].q[i] > tun_pkg::UNIT) ? tun_pkg::UNIT : dv_s[DS-1].q[i];
			if (dv_s[DS-1].deg) nv[i] = '0;
			else if (dv_s[DS-1].neg[i]) nv[i] = OW'(-qc[i]);
			else nv[i] = OW'(qc[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (en) vld_q <= dvv_s[DS-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_q <= nv;
			deg_q <= dv_s[DS-1].deg;
			last_q <= dv_s[DS-1].last;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata = {{(tun_pkg::OUT_BYTES*8-3*OW){1'b0}}, nrm_q[2], nrm_q[1], nrm_q[0]};
	assign m_tuser = deg_q;
	assign m_tlast = last_q;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("degenerate item carries a nonzero normal");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(nrm_q[0]) <= $signed(tun_pkg::UNIT))
			&& ($signed(nrm_q[0]) >= -$signed(tun_pkg::UNIT))
			&& ($signed(nrm_q[1]) <= $signed(tun_pkg::UNIT))
			&& ($signed(nrm_q[1]) >= -$signed(tun_pkg::UNIT))
			&& ($signed(nrm_q[2]) <= $signed(tun_pkg::UNIT))
			&& ($signed(nrm_q[2]) >= -$signed(tun_pkg::UNIT)))
		else $error("normal component exceeds one");

	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !deg_s5 |-> m_s5[0][NT-1] || m_s5[1][NT-1] || m_s5[2][NT-1])
		else $error("normalized magnitudes miss the top bit");

endmodule
